// ===== src/pidl_pkg.sv =====
`default_nettype none
package pidl_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    localparam int WORD_W = 32;
    localparam int POS_W  = 6;

    typedef struct packed {
        logic load_val;
        logic shift_up;
        logic shift_down;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== src/positional_insert_delete_list.sv =====
// The result is in the output register in the cycle after the request is taken.
// One request per cycle unless stalled; cells at and above the position shift.
// A new request is taken while a result waits only if that result is taken too.
// Reset (synchronous, active low) empties the list and drops the pending result.
// Stored words are not reset.
`default_nettype none
module positional_insert_delete_list
    import pidl_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [1:0]               i_mode,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [WORD_W-1:0] i_value,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [1:0]                    o_status,
    output logic signed [WORD_W-1:0]      o_data,
    output logic [POS_W-1:0]              o_count
);

    localparam int UW = $clog2(DEPTH + 1);
    localparam int IW = ((UW > POS_W) ? UW : POS_W) + 1;
    localparam int RD = (DEPTH < 64) ? DEPTH : 64;

    logic [UW-1:0]            r_used;
    logic [UW-1:0]            n_used;
    logic                     r_valid;
    logic [1:0]               r_status;
    logic signed [WORD_W-1:0] r_data;
    logic [POS_W-1:0]         r_count;

    t_mode                    w_mode;
    t_status                  w_status;
    logic signed [WORD_W-1:0] w_rd;
    logic signed [WORD_W-1:0] w_data;
    logic [POS_W-1:0]         w_pidx;
    logic [IW-1:0]            w_pos;
    logic [IW-1:0]            w_used;
    logic                     w_accept;
    logic                     w_ins_ok;
    logic                     w_del_ok;
    logic signed [WORD_W-1:0] w_q [DEPTH];

    assign w_mode   = t_mode'(i_mode);
    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_pidx   = i_position - POS_W'(1);
    assign w_pos    = IW'(i_position);
    assign w_used   = IW'(r_used);

    always_comb begin
        w_rd = '0;
        for (int j = 0; j < RD; j++) begin
            if (w_pidx == POS_W'(j)) begin
                w_rd = w_q[j];
            end
        end
    end

    always_comb begin
        w_status = ST_OK;
        w_data   = '0;
        w_ins_ok = 1'b0;
        w_del_ok = 1'b0;
        n_used   = r_used;
        case (w_mode)
            MODE_CLEAR: begin
                n_used = '0;
            end
            MODE_INSERT: begin
                if (w_pos == '0 || w_pos > w_used + IW'(1)) begin
                    w_status = ST_BADPOS;
                end else if (w_used >= IW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins_ok = 1'b1;
                    n_used   = r_used + UW'(1);
                end
            end
            MODE_DELETE, MODE_READ: begin
                if (r_used == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_pos == '0 || w_pos > w_used) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_data = w_rd;
                    if (w_mode == MODE_DELETE) begin
                        w_del_ok = 1'b1;
                        n_used   = r_used - UW'(1);
                    end
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_cell_ctrl               w_ctrl;
        logic                     w_here;
        logic                     w_above;
        logic signed [WORD_W-1:0] w_left;
        logic signed [WORD_W-1:0] w_right;

        assign w_here  = (IW'(w_pidx) == IW'(k));
        assign w_above = (IW'(k) > IW'(w_pidx));

        assign w_ctrl.load_val   = w_accept && w_ins_ok && w_here;
        assign w_ctrl.shift_up   = w_accept && w_ins_ok && w_above;
        assign w_ctrl.shift_down = w_accept && w_del_ok && (w_here || w_above);

        if (k == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid
            assign w_left = w_q[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = w_q[k];
        end else begin : g_inner
            assign w_right = w_q[k+1];
        end

        pidl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_q     (w_q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_used  <= n_used;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_data   <= w_data;
            r_count  <= POS_W'(n_used);
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_count  = r_count;

endmodule
`default_nettype wire

// ===== src/pidl_cell.sv =====
`default_nettype none
module pidl_cell
    import pidl_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_cell_ctrl               i_ctrl,
    input  wire logic signed [WORD_W-1:0] i_value,
    input  wire logic signed [WORD_W-1:0] i_left,
    input  wire logic signed [WORD_W-1:0] i_right,
    output logic signed [WORD_W-1:0]      o_q
);

    logic signed [WORD_W-1:0] r_q;
    logic signed [WORD_W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctrl.load_val) begin
            n_q = i_value;
        end else if (i_ctrl.shift_up) begin
            n_q = i_left;
        end else if (i_ctrl.shift_down) begin
            n_q = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// ===== src/pidl_checker.sv =====
`default_nettype none
module pidl_checker
    import pidl_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_ready,
    input wire logic                     o_valid,
    input wire logic                     i_ready,
    input wire logic [1:0]               o_status,
    input wire logic signed [WORD_W-1:0] o_data,
    input wire logic [POS_W-1:0]         o_count
);

    localparam logic [POS_W-1:0] FULL_CNT = POS_W'(DEPTH);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data) && $stable(o_status)
            && $stable(o_count))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("request stalled without a pending result");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_data == '0)
        else $error("rejected request returned data");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_count == '0)
        else $error("empty status with nonzero count");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_count == FULL_CNT)
        else $error("full status with wrong count");

endmodule

bind positional_insert_delete_list pidl_checker #(.DEPTH(DEPTH)) u_pidl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_status (o_status),
    .o_data   (o_data),
    .o_count  (o_count)
);
`default_nettype wire
